// ===== design/vfk_pkg.sv =====
// Shared types, codes and constants of the voice fade and key-off controller.
package vfk_pkg;

    // Default number of voice slots.
    localparam int VOICES_DEF = 24;

    // Field widths.
    localparam int VOICE_W  = 5;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 16;
    localparam int MASK_W   = 24;

    // Fixed-point shift applied to volume times level.
    localparam int LEVEL_SHIFT = 8;

    // Item function codes.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Key status codes.
    localparam logic [STATUS_W-1:0] STATUS_OFF        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ON_ENV_OFF = 2'd3;

    // One input item as held in the input register.
    typedef struct packed {
        logic                func;
        logic [VOICE_W-1:0]  voice;
        logic [STATUS_W-1:0] key_status;
        logic                last_voice;
        logic [DATA_W-1:0]   level_in;
        logic [DATA_W-1:0]   fade_step_in;
        logic [DATA_W-1:0]   hold_ticks_in;
        logic [DATA_W-1:0]   volume_left_in;
        logic [DATA_W-1:0]   volume_right_in;
    } t_item;

    // Outcome of the state update, carried to the scaling stage.
    typedef struct packed {
        logic              write_volume;
        logic [DATA_W-1:0] level;
        logic [DATA_W-1:0] volume_left;
        logic [DATA_W-1:0] volume_right;
        logic              key_off_now;
        logic [MASK_W-1:0] key_off_mask;
        logic              tick_done;
        logic [MASK_W-1:0] active_voices;
    } t_mid;

    // One result item as held in the output register.
    typedef struct packed {
        logic              write_volume;
        logic [DATA_W-1:0] left_level;
        logic [DATA_W-1:0] right_level;
        logic              key_off_now;
        logic [MASK_W-1:0] key_off_mask;
        logic              tick_done;
        logic [MASK_W-1:0] active_voices;
    } t_result;

endpackage

// ===== design/vfk_if.sv =====
// Valid/ready channel interfaces for input items and result items.
interface vfk_in_if;
    logic                            valid;
    logic                            ready;
    logic                            func;
    logic [vfk_pkg::VOICE_W-1:0]     voice;
    logic [vfk_pkg::STATUS_W-1:0]    key_status;
    logic                            last_voice;
    logic [vfk_pkg::DATA_W-1:0]      level_in;
    logic [vfk_pkg::DATA_W-1:0]      fade_step_in;
    logic [vfk_pkg::DATA_W-1:0]      hold_ticks_in;
    logic [vfk_pkg::DATA_W-1:0]      volume_left_in;
    logic [vfk_pkg::DATA_W-1:0]      volume_right_in;

    modport source (
        output valid, func, voice, key_status, last_voice, level_in, fade_step_in,
               hold_ticks_in, volume_left_in, volume_right_in,
        input  ready
    );

    modport sink (
        input  valid, func, voice, key_status, last_voice, level_in, fade_step_in,
               hold_ticks_in, volume_left_in, volume_right_in,
        output ready
    );
endinterface

interface vfk_out_if;
    logic                         valid;
    logic                         ready;
    logic                         write_volume;
    logic [vfk_pkg::DATA_W-1:0]   left_level;
    logic [vfk_pkg::DATA_W-1:0]   right_level;
    logic                         key_off_now;
    logic [vfk_pkg::MASK_W-1:0]   key_off_mask;
    logic                         tick_done;
    logic [vfk_pkg::MASK_W-1:0]   active_voices;

    modport source (
        output valid, write_volume, left_level, right_level, key_off_now,
               key_off_mask, tick_done, active_voices,
        input  ready
    );

    modport sink (
        input  valid, write_volume, left_level, right_level, key_off_now,
               key_off_mask, tick_done, active_voices,
        output ready
    );
endinterface

// ===== design/vfk_state.sv =====
// Per-voice state store with the fade, timer and key-off update for one item.
module vfk_state #(
    parameter int VOICES = vfk_pkg::VOICES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  vfk_pkg::t_item i_item,
    output vfk_pkg::t_mid  o_mid
);
    localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

    // Voice slot registers.
    logic [vfk_pkg::DATA_W-1:0] r_level [VOICES];
    logic [vfk_pkg::DATA_W-1:0] r_step  [VOICES];
    logic [vfk_pkg::DATA_W-1:0] r_timer [VOICES];
    logic [vfk_pkg::DATA_W-1:0] r_vol_l [VOICES];
    logic [vfk_pkg::DATA_W-1:0] r_vol_r [VOICES];
    logic [vfk_pkg::MASK_W-1:0] r_active;
    logic [vfk_pkg::MASK_W-1:0] r_keyoff;

    logic [vfk_pkg::MASK_W-1:0] n_active;
    logic [vfk_pkg::MASK_W-1:0] n_keyoff;
    logic [vfk_pkg::DATA_W-1:0] n_level;
    logic [vfk_pkg::DATA_W-1:0] n_step;
    logic [vfk_pkg::DATA_W-1:0] n_timer;

    logic                       slot_ok;
    logic [IDX_W-1:0]           idx;
    logic [vfk_pkg::MASK_W-1:0] vbit;
    logic [vfk_pkg::DATA_W-1:0] cur_level;
    logic [vfk_pkg::DATA_W-1:0] cur_step;
    logic [vfk_pkg::DATA_W-1:0] cur_timer;
    logic [vfk_pkg::DATA_W-1:0] cur_vol_l;
    logic [vfk_pkg::DATA_W-1:0] cur_vol_r;
    logic                       is_tick;

    // Address decode and read of the addressed slot.
    assign slot_ok   = ({1'b0, i_item.voice} < 6'(VOICES));
    assign idx       = i_item.voice[IDX_W-1:0];
    assign vbit      = vfk_pkg::MASK_W'(1) << i_item.voice;
    assign is_tick   = (i_item.func == vfk_pkg::FUNC_TICK);
    assign cur_level = slot_ok ? r_level[idx] : '0;
    assign cur_step  = slot_ok ? r_step[idx]  : '0;
    assign cur_timer = slot_ok ? r_timer[idx] : '0;
    assign cur_vol_l = slot_ok ? r_vol_l[idx] : '0;
    assign cur_vol_r = slot_ok ? r_vol_r[idx] : '0;

    // Next state and the outcome of this item.
    always_comb begin
        n_active = r_active;
        n_keyoff = r_keyoff;
        n_level  = cur_level;
        n_step   = cur_step;
        n_timer  = cur_timer;
        o_mid    = '0;
        o_mid.volume_left  = cur_vol_l;
        o_mid.volume_right = cur_vol_r;
        if (!is_tick) begin
            if (slot_ok) begin
                n_level  = i_item.level_in;
                n_step   = i_item.fade_step_in;
                n_timer  = i_item.hold_ticks_in;
                n_active = r_active | vbit;
            end
            o_mid.key_off_mask = r_keyoff;
        end else begin
            if (slot_ok) begin
                // Fade the level down and saturate at zero.
                if (cur_step != '0) begin
                    if (cur_step >= cur_level) begin
                        n_level = '0;
                    end else begin
                        n_level = cur_level - cur_step;
                    end
                    if (n_level != '0) begin
                        o_mid.write_volume = 1'b1;
                    end else begin
                        n_active          = n_active & ~vbit;
                        n_step            = '0;
                        o_mid.key_off_now = 1'b1;
                        n_keyoff          = n_keyoff | vbit;
                    end
                end
                // Hold timer expiry keys off a sounding voice.
                if (cur_timer != '0) begin
                    n_timer = cur_timer - vfk_pkg::DATA_W'(1);
                    if (n_timer == '0 && i_item.key_status != vfk_pkg::STATUS_OFF) begin
                        o_mid.key_off_now = 1'b1;
                        n_keyoff          = n_keyoff | vbit;
                    end
                end
                // Key on with the envelope off keys off once per tick.
                if (i_item.key_status == vfk_pkg::STATUS_ON_ENV_OFF &&
                    (n_keyoff & vbit) == '0 && !(o_mid.key_off_now && vbit == '0)) begin
                    o_mid.key_off_now = 1'b1;
                    n_keyoff          = n_keyoff | vbit;
                end
            end
            o_mid.key_off_mask = n_keyoff;
            if (i_item.last_voice) begin
                o_mid.tick_done = 1'b1;
                n_keyoff        = '0;
            end
        end
        o_mid.level         = n_level;
        o_mid.active_voices = n_active;
    end

    // Slot registers, written once per item as it leaves the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < VOICES; k++) begin
                r_level[k] <= '0;
                r_step[k]  <= '0;
                r_timer[k] <= '0;
                r_vol_l[k] <= '0;
                r_vol_r[k] <= '0;
            end
            r_active <= '0;
            r_keyoff <= '0;
        end else if (i_en) begin
            if (slot_ok) begin
                r_level[idx] <= n_level;
                r_step[idx]  <= n_step;
                r_timer[idx] <= n_timer;
                if (!is_tick) begin
                    r_vol_l[idx] <= i_item.volume_left_in;
                    r_vol_r[idx] <= i_item.volume_right_in;
                end
            end
            r_active <= n_active;
            r_keyoff <= n_keyoff;
        end
    end

`ifndef NO_ASSERTIONS
    // The gathered mask is empty after the item that closes a tick.
    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && is_tick && i_item.last_voice |=> r_keyoff == '0)
        else $error("key-off mask not cleared after the last voice");

    // A load item leaves the gathered mask as it was.
    a_load_keeps_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && !is_tick |=> r_keyoff == $past(r_keyoff))
        else $error("load item changed the key-off mask");

    // Without an item the voice bits do not move.
    a_idle_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_active) && $stable(r_keyoff))
        else $error("voice bits changed without an item");
`endif

endmodule

// ===== design/vfk_scale.sv =====
// Volume scaling of the faded level for the left and right channels.
module vfk_scale (
    input  vfk_pkg::t_mid    i_mid,
    output vfk_pkg::t_result o_res
);
    logic [2*vfk_pkg::DATA_W-1:0] prod_l;
    logic [2*vfk_pkg::DATA_W-1:0] prod_r;

    // Volume times level, shifted down and kept to the low result bits.
    assign prod_l = i_mid.volume_left  * i_mid.level;
    assign prod_r = i_mid.volume_right * i_mid.level;

    always_comb begin
        o_res               = '0;
        o_res.write_volume  = i_mid.write_volume;
        o_res.key_off_now   = i_mid.key_off_now;
        o_res.key_off_mask  = i_mid.key_off_mask;
        o_res.tick_done     = i_mid.tick_done;
        o_res.active_voices = i_mid.active_voices;
        if (i_mid.write_volume) begin
            o_res.left_level  = prod_l[vfk_pkg::LEVEL_SHIFT +: vfk_pkg::DATA_W];
            o_res.right_level = prod_r[vfk_pkg::LEVEL_SHIFT +: vfk_pkg::DATA_W];
        end
    end
endmodule

// ===== design/voice_fade_keyoff_controller_top.sv =====
// Top level of the voice fade and key-off controller.
//
//  Port    | Dir | Handshake     | Carries
//  i_in    | in  | valid / ready | load or tick item for one voice
//  o_out   | out | valid / ready | scaled volumes, key-off flags and masks
//
// An item passes three registers: input, state update, result. One item is taken per
// cycle while the output does not stall, set by the single read-modify-write of the voice
// slot registers.
// Reset is synchronous and active low and clears all voice slots and masks.
// A stalled output holds each stage in place; i_in.ready drops only when the
// input register is full and cannot move on.
module voice_fade_keyoff_controller_top #(
    parameter int VOICES = vfk_pkg::VOICES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vfk_in_if.sink    i_in,
    vfk_out_if.source o_out
);
    logic             r_s0_valid;
    logic             r_s1_valid;
    logic             r_s2_valid;
    vfk_pkg::t_item   r_s0;
    vfk_pkg::t_mid    r_s1;
    vfk_pkg::t_result r_s2;

    vfk_pkg::t_item   in_item;
    vfk_pkg::t_mid    n_s1;
    vfk_pkg::t_result n_s2;

    logic s2_free;
    logic s1_move;
    logic s1_free;
    logic s0_move;
    logic s0_free;

    // Stage advance control.
    assign s2_free    = !r_s2_valid || o_out.ready;
    assign s1_move    = r_s1_valid && s2_free;
    assign s1_free    = !r_s1_valid || s1_move;
    assign s0_move    = r_s0_valid && s1_free;
    assign s0_free    = !r_s0_valid || s0_move;
    assign i_in.ready = s0_free;

    // Gather the input item.
    always_comb begin
        in_item.func            = i_in.func;
        in_item.voice           = i_in.voice;
        in_item.key_status      = i_in.key_status;
        in_item.last_voice      = i_in.last_voice;
        in_item.level_in        = i_in.level_in;
        in_item.fade_step_in    = i_in.fade_step_in;
        in_item.hold_ticks_in   = i_in.hold_ticks_in;
        in_item.volume_left_in  = i_in.volume_left_in;
        in_item.volume_right_in = i_in.volume_right_in;
    end

    vfk_state #(
        .VOICES (VOICES)
    ) u_state (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (s0_move),
        .i_item (r_s0),
        .o_mid  (n_s1)
    );

    vfk_scale u_scale (
        .i_mid(r_s1),
        .o_res(n_s2)
    );

    // Valid bits of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s0_free) begin
                r_s0_valid <= i_in.valid;
            end
            if (s1_free) begin
                r_s1_valid <= r_s0_valid;
            end
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    // Stage payload registers.
    always_ff @(posedge i_clk) begin
        if (s0_free && i_in.valid) begin
            r_s0 <= in_item;
        end
        if (s0_move) begin
            r_s1 <= n_s1;
        end
        if (s1_move) begin
            r_s2 <= n_s2;
        end
    end

    // Result channel.
    assign o_out.valid         = r_s2_valid;
    assign o_out.write_volume  = r_s2.write_volume;
    assign o_out.left_level    = r_s2.left_level;
    assign o_out.right_level   = r_s2.right_level;
    assign o_out.key_off_now   = r_s2.key_off_now;
    assign o_out.key_off_mask  = r_s2.key_off_mask;
    assign o_out.tick_done     = r_s2.tick_done;
    assign o_out.active_voices = r_s2.active_voices;

`ifndef NO_ASSERTIONS
    // Reset empties every stage.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_s0_valid && !r_s1_valid && !r_s2_valid)
        else $error("pipeline not empty after reset");

    // An input item blocked by the update stage stays in place.
    a_s0_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s0_valid && !s1_free |=> r_s0_valid && $stable(r_s0))
        else $error("input register lost a blocked item");

    // An updated item blocked by the result register stays in place.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s2_free |=> r_s1_valid && $stable(r_s1))
        else $error("update stage lost a blocked item");
`endif

endmodule

// ===== tb/tb_voice_fade_keyoff_controller_top.sv =====
// Testbench of the voice fade and key-off controller, checked against a predictor.
`timescale 1ns / 100ps

module tb_voice_fade_keyoff_controller_top;

    localparam int NUM_VOICES     = vfk_pkg::VOICES_DEF;
    localparam int RANDOM_ITEMS   = 1150;
    localparam int QUIET_LIMIT    = 2000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int CALM_FIRST     = 500;
    localparam int CALM_LAST      = 700;
    localparam int IDLE_PCT       = 29;

    // Key status codes that the package leaves unnamed.
    localparam logic [vfk_pkg::STATUS_W-1:0] STATUS_ON         = 2'd1;
    localparam logic [vfk_pkg::STATUS_W-1:0] STATUS_OFF_ENV_ON = 2'd2;

    // One queued input item; drain holds it back until all results are in.
    typedef struct {
        vfk_pkg::t_item item;
        bit             drain;
    } t_cmd_entry;

    logic clk;
    logic rst_n;

    vfk_in_if  in_ch ();
    vfk_out_if out_ch ();

    voice_fade_keyoff_controller_top i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_cmd_entry       voice_cmds_q[$];
    vfk_pkg::t_result voice_results_q[$];
    vfk_pkg::t_item   drv_item;
    bit               drain_next;
    int               mismatch_count;
    int               items_taken;
    int               results_seen;
    int               quiet_cycles;

    // Predicted voice slot state.
    logic [vfk_pkg::DATA_W-1:0] lvl_mem   [NUM_VOICES];
    logic [vfk_pkg::DATA_W-1:0] step_mem  [NUM_VOICES];
    logic [vfk_pkg::DATA_W-1:0] hold_mem  [NUM_VOICES];
    logic [vfk_pkg::DATA_W-1:0] vol_l_mem [NUM_VOICES];
    logic [vfk_pkg::DATA_W-1:0] vol_r_mem [NUM_VOICES];
    logic [vfk_pkg::MASK_W-1:0] active_now;
    logic [vfk_pkg::MASK_W-1:0] keyoff_gather;

    // Volume times level in fixed point, shifted down by 8 bits and kept to 16 bits.
    function automatic logic [vfk_pkg::DATA_W-1:0] scale_by_level(
        input logic [vfk_pkg::DATA_W-1:0] vol,
        input logic [vfk_pkg::DATA_W-1:0] lvl);
        logic [2*vfk_pkg::DATA_W-1:0] prod;
        prod = vol * lvl;
        return prod[vfk_pkg::LEVEL_SHIFT +: vfk_pkg::DATA_W];
    endfunction

    // Applies one item to the predicted state and returns the result it should give.
    function automatic vfk_pkg::t_result predict_voice_step(input vfk_pkg::t_item it);
        vfk_pkg::t_result           r;
        logic [vfk_pkg::MASK_W-1:0] vbit;
        logic                       in_range;
        int                         v;
        r        = '0;
        v        = int'(it.voice);
        in_range = (v < NUM_VOICES);
        vbit     = '0;
        if (in_range) begin
            vbit[v] = 1'b1;
        end
        if (it.func == vfk_pkg::FUNC_LOAD) begin
            if (in_range) begin
                lvl_mem[v]   = it.level_in;
                step_mem[v]  = it.fade_step_in;
                hold_mem[v]  = it.hold_ticks_in;
                vol_l_mem[v] = it.volume_left_in;
                vol_r_mem[v] = it.volume_right_in;
                active_now   = active_now | vbit;
            end
            r.key_off_mask = keyoff_gather;
        end else begin
            if (in_range) begin
                // Fade: saturating drop, then either scaled volumes or key-off.
                if (step_mem[v] != '0) begin
                    if (step_mem[v] >= lvl_mem[v]) begin
                        lvl_mem[v] = '0;
                    end else begin
                        lvl_mem[v] = lvl_mem[v] - step_mem[v];
                    end
                    if (lvl_mem[v] != '0) begin
                        r.write_volume = 1'b1;
                        r.left_level   = scale_by_level(vol_l_mem[v], lvl_mem[v]);
                        r.right_level  = scale_by_level(vol_r_mem[v], lvl_mem[v]);
                    end else begin
                        active_now    = active_now & ~vbit;
                        step_mem[v]   = '0;
                        r.key_off_now = 1'b1;
                        keyoff_gather = keyoff_gather | vbit;
                    end
                end
                // Hold timer expiry keys off a voice that is sounding.
                if (hold_mem[v] != '0) begin
                    hold_mem[v] = hold_mem[v] - vfk_pkg::DATA_W'(1);
                    if (hold_mem[v] == '0 && it.key_status != vfk_pkg::STATUS_OFF) begin
                        r.key_off_now = 1'b1;
                        keyoff_gather = keyoff_gather | vbit;
                    end
                end
                // Envelope-off status keys off unless already gathered this tick.
                if (it.key_status == vfk_pkg::STATUS_ON_ENV_OFF &&
                    (keyoff_gather & vbit) == '0) begin
                    r.key_off_now = 1'b1;
                    keyoff_gather = keyoff_gather | vbit;
                end
            end
            r.key_off_mask = keyoff_gather;
            if (it.last_voice) begin
                r.tick_done   = 1'b1;
                keyoff_gather = '0;
            end
        end
        r.active_voices = active_now;
        return r;
    endfunction

    // Queues one item, carrying a pending drain request with it.
    task automatic queue_item(input vfk_pkg::t_item it);
        t_cmd_entry e;
        e.item     = it;
        e.drain    = drain_next;
        drain_next = 1'b0;
        voice_cmds_q.push_back(e);
    endtask

    task automatic push_load(input int v, input int lvl, input int step, input int hold,
                             input int vl, input int vr);
        vfk_pkg::t_item it;
        it.func            = vfk_pkg::FUNC_LOAD;
        it.voice           = vfk_pkg::VOICE_W'(v);
        it.key_status      = vfk_pkg::STATUS_W'($urandom_range(3));
        it.last_voice      = 1'($urandom_range(1));
        it.level_in        = vfk_pkg::DATA_W'(lvl);
        it.fade_step_in    = vfk_pkg::DATA_W'(step);
        it.hold_ticks_in   = vfk_pkg::DATA_W'(hold);
        it.volume_left_in  = vfk_pkg::DATA_W'(vl);
        it.volume_right_in = vfk_pkg::DATA_W'(vr);
        queue_item(it);
    endtask

    // Tick items carry random payload, which the block ignores.
    task automatic push_tick(input int v, input logic [vfk_pkg::STATUS_W-1:0] status,
                             input bit last);
        vfk_pkg::t_item it;
        it.func            = vfk_pkg::FUNC_TICK;
        it.voice           = vfk_pkg::VOICE_W'(v);
        it.key_status      = status;
        it.last_voice      = last;
        it.level_in        = vfk_pkg::DATA_W'($urandom());
        it.fade_step_in    = vfk_pkg::DATA_W'($urandom());
        it.hold_ticks_in   = vfk_pkg::DATA_W'($urandom());
        it.volume_left_in  = vfk_pkg::DATA_W'($urandom());
        it.volume_right_in = vfk_pkg::DATA_W'($urandom());
        queue_item(it);
    endtask

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
            mismatch_count++;
        end
    endtask

    // Clock.
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Input driver: offers queued items, with random gaps and two drain pauses.
    always @(posedge clk) begin : input_driver
        t_cmd_entry nxt;
        bit         in_gap;
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                voice_results_q.push_back(predict_voice_step(drv_item));
                items_taken <= items_taken + 1;
            end
            in_gap = !(items_taken >= CALM_FIRST && items_taken < CALM_LAST) &&
                     ($urandom_range(99) < IDLE_PCT);
            if (!in_ch.valid || in_ch.ready) begin
                if (voice_cmds_q.size() != 0 && !in_gap &&
                    (!voice_cmds_q[0].drain || voice_results_q.size() == 0)) begin
                    nxt = voice_cmds_q.pop_front();
                    drv_item                 <= nxt.item;
                    in_ch.valid              <= 1'b1;
                    in_ch.func               <= nxt.item.func;
                    in_ch.voice              <= nxt.item.voice;
                    in_ch.key_status         <= nxt.item.key_status;
                    in_ch.last_voice         <= nxt.item.last_voice;
                    in_ch.level_in           <= nxt.item.level_in;
                    in_ch.fade_step_in       <= nxt.item.fade_step_in;
                    in_ch.hold_ticks_in      <= nxt.item.hold_ticks_in;
                    in_ch.volume_left_in     <= nxt.item.volume_left_in;
                    in_ch.volume_right_in    <= nxt.item.volume_right_in;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: random stalls, and every accepted result checked in order.
    always @(posedge clk) begin : result_monitor
        vfk_pkg::t_result want;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen <= results_seen + 1;
                if (voice_results_q.size() == 0) begin
                    $error("result item arrived with no item pending");
                    mismatch_count++;
                end else begin
                    want = voice_results_q.pop_front();
                    check_field("write_volume", 32'(want.write_volume),
                                32'(out_ch.write_volume));
                    check_field("left_level", 32'(want.left_level), 32'(out_ch.left_level));
                    check_field("right_level", 32'(want.right_level),
                                32'(out_ch.right_level));
                    check_field("key_off_now", 32'(want.key_off_now),
                                32'(out_ch.key_off_now));
                    check_field("key_off_mask", 32'(want.key_off_mask),
                                32'(out_ch.key_off_mask));
                    check_field("tick_done", 32'(want.tick_done), 32'(out_ch.tick_done));
                    check_field("active_voices", 32'(want.active_voices),
                                32'(out_ch.active_voices));
                end
            end
            out_ch.ready <= (results_seen >= CALM_FIRST && results_seen < CALM_LAST) ||
                            ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog on cycles where neither side moves an item.
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus, reset and end of run.
    initial begin : stimulus
        int  base;
        int  n;
        int  lvl;
        int  step;
        int  hold;
        int  pick;
        bit  drain_done;
        logic [vfk_pkg::STATUS_W-1:0] st;

        rst_n                 = 1'b0;
        in_ch.valid           = 1'b0;
        in_ch.func            = vfk_pkg::FUNC_LOAD;
        in_ch.voice           = '0;
        in_ch.key_status      = vfk_pkg::STATUS_OFF;
        in_ch.last_voice      = 1'b0;
        in_ch.level_in        = '0;
        in_ch.fade_step_in    = '0;
        in_ch.hold_ticks_in   = '0;
        in_ch.volume_left_in  = '0;
        in_ch.volume_right_in = '0;
        out_ch.ready          = 1'b0;
        drv_item              = '0;
        drain_next            = 1'b0;
        drain_done            = 1'b0;
        mismatch_count        = 0;
        items_taken           = 0;
        results_seen          = 0;
        quiet_cycles          = 0;
        active_now            = '0;
        keyoff_gather         = '0;
        for (int i = 0; i < NUM_VOICES; i++) begin
            lvl_mem[i]   = '0;
            step_mem[i]  = '0;
            hold_mem[i]  = '0;
            vol_l_mem[i] = '0;
            vol_r_mem[i] = '0;
        end

        // Envelope-off on an idle voice, then again once its bit is gathered.
        push_tick(0, vfk_pkg::STATUS_ON_ENV_OFF, 1'b0);
        push_tick(0, vfk_pkg::STATUS_ON_ENV_OFF, 1'b1);
        // Loads at the extremes, including a slot beyond the last voice.
        push_load(0, 16'hFFFF, 1, 2, 16'hFFFF, 16'h0000);
        push_load(23, 16'h0100, 16'h0100, 0, 16'h1234, 16'hFFFF);
        push_load(31, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_tick(0, STATUS_ON, 1'b0);
        push_tick(23, vfk_pkg::STATUS_OFF, 1'b0);
        push_tick(31, vfk_pkg::STATUS_ON_ENV_OFF, 1'b1);
        // Timer expiry with a sounding voice, then envelope-off already gathered.
        push_tick(0, STATUS_OFF_ENV_ON, 1'b0);
        push_tick(0, vfk_pkg::STATUS_ON_ENV_OFF, 1'b1);
        // Step larger than the level, timer running out on a silent voice.
        push_load(5, 100, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF);
        push_tick(5, vfk_pkg::STATUS_OFF, 1'b1);
        // No fade step: no volume write.
        push_load(7, 16'hFFFF, 0, 0, 16'hFFFF, 16'hFFFF);
        push_tick(7, STATUS_ON, 1'b0);
        // Zero level with zero step.
        push_load(1, 0, 0, 0, 0, 0);
        push_tick(1, vfk_pkg::STATUS_ON_ENV_OFF, 1'b1);
        // Smallest nonzero level after the drop.
        push_load(2, 2, 1, 0, 16'hFFFF, 16'h8001);
        push_tick(2, STATUS_ON, 1'b0);
        push_tick(2, STATUS_ON, 1'b1);
        push_load(0, 0, 0, 0, 0, 0);
        push_tick(31, vfk_pkg::STATUS_OFF, 1'b0);
        push_tick(24, STATUS_ON, 1'b1);

        // Random part: load bursts, tick sweeps over the voices, and noise.
        drain_next = 1'b1;
        base       = voice_cmds_q.size();
        while (voice_cmds_q.size() - base < RANDOM_ITEMS) begin
            if (!drain_done && voice_cmds_q.size() - base >= RANDOM_ITEMS / 2) begin
                drain_next = 1'b1;
                drain_done = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 20) begin
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++) begin
                    lvl = ($urandom_range(9) == 0) ? 16'hFFFF : $urandom_range(1, 16'hFFFF);
                    case ($urandom_range(9))
                        0, 1:          step = 0;
                        2, 3, 4, 5, 6: step = $urandom_range(1, lvl / 4 + 1);
                        7, 8:          step = $urandom_range(16'hFFFF);
                        default:       step = 16'hFFFF;
                    endcase
                    case ($urandom_range(9))
                        0, 1, 2, 3: hold = 0;
                        4, 5, 6, 7: hold = $urandom_range(1, 6);
                        8:          hold = $urandom_range(16'hFFFF);
                        default:    hold = 16'hFFFF;
                    endcase
                    push_load(($urandom_range(9) == 0) ? $urandom_range(24, 31)
                                                       : $urandom_range(23),
                              lvl, step, hold, $urandom_range(16'hFFFF),
                              ($urandom_range(7) == 0) ? 16'hFFFF : $urandom_range(16'hFFFF));
                end
            end else if (pick < 90) begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: n = NUM_VOICES;
                    6, 7, 8:          n = $urandom_range(1, NUM_VOICES);
                    default:          n = 32;
                endcase
                for (int v = 0; v < n; v++) begin
                    case ($urandom_range(9))
                        0, 1, 2, 3, 4: st = STATUS_ON;
                        5, 6:          st = vfk_pkg::STATUS_OFF;
                        7, 8:          st = STATUS_OFF_ENV_ON;
                        default:       st = vfk_pkg::STATUS_ON_ENV_OFF;
                    endcase
                    push_tick(v, st, (v == n - 1) || ($urandom_range(49) == 0));
                end
            end else begin
                if ($urandom_range(1) == 0) begin
                    push_load($urandom_range(31), $urandom(), $urandom(), $urandom(),
                              $urandom(), $urandom());
                end else begin
                    push_tick($urandom_range(31), vfk_pkg::STATUS_W'($urandom_range(3)),
                              1'($urandom_range(1)));
                end
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every item to go in and every result to come back.
        while (voice_cmds_q.size() != 0 || in_ch.valid || voice_results_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (voice_results_q.size() != 0) begin
            $error("%0d result items never arrived", voice_results_q.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
